[hw/rtl/msr_pkg.sv]
// Shared types and constants for the shard router: hash constants,
// datapath op codes, controller states and command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

    localparam int HASH_W         = 32;
    localparam int SHARD_W        = 16;
    localparam int SHARD_BITS_W   = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int MAX_SHARD_BITS_DEF = 16;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARD_BITS = 1'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ABSORB,     // take one request, start key if needed
        OP_BLK_C1,     // work *= C1
        OP_BLK_C2,     // work = rotl15(work) * C2
        OP_BLK_FOLD,   // h = rotl13(h ^ work) * 5 + ADD
        OP_TAIL_C1,    // work = partial * C1
        OP_TAIL_FOLD,  // h ^= work
        OP_FIN_C1,     // work = fmix16(h ^ len) * FC1
        OP_FIN_C2,     // work = (work ^ work >> 13) * FC2
        OP_OUT         // load output register, end key
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLK_C1,
        ST_BLK_C2,
        ST_BLK_FOLD,
        ST_TAIL_C1,
        ST_TAIL_C2,
        ST_TAIL_FOLD,
        ST_FIN_C2,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic word_full;     // absorbing this byte completes a word
        logic tail_pending;  // leftover bytes in partial word
        logic out_free;      // output register can take a result
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/msr_ctrl.sv]
// Sequencer for the shard router: accepts requests and steps the datapath
// through block mix, tail mix and finalizer. Depends on msr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msr_ctrl
    import msr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       s_tuser,   // has_byte
    input  wire logic       s_tlast,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        last_pend_reg, last_pend_next;
    logic        take;

    assign take = s_tvalid && (s_tuser || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

    // next state
    always_comb begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    last_pend_next = s_tlast;
                    if (s_tuser && status.word_full) begin
                        state_next = ST_BLK_C1;
                    end else if (s_tlast) begin
                        state_next = ST_TAIL_C1;
                    end
                end
            end
            ST_BLK_C1:   state_next = ST_BLK_C2;
            ST_BLK_C2:   state_next = ST_BLK_FOLD;
            ST_BLK_FOLD: state_next = last_pend_reg ? ST_TAIL_C1 : ST_IDLE;
            ST_TAIL_C1:  state_next = status.tail_pending ? ST_TAIL_C2 : ST_FIN_C2;
            ST_TAIL_C2:  state_next = ST_TAIL_FOLD;
            ST_TAIL_FOLD: state_next = ST_TAIL_C1;
            ST_FIN_C2:   state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs; ST_TAIL_C1 runs the first finalizer multiply when no tail is left
    always_comb begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (take) begin
                    cmd.op = OP_ABSORB;
                end
            end
            ST_BLK_C1:    cmd.op = OP_BLK_C1;
            ST_BLK_C2:    cmd.op = OP_BLK_C2;
            ST_BLK_FOLD:  cmd.op = OP_BLK_FOLD;
            ST_TAIL_C1:   cmd.op = status.tail_pending ? OP_TAIL_C1 : OP_FIN_C1;
            ST_TAIL_C2:   cmd.op = OP_BLK_C2;
            ST_TAIL_FOLD: cmd.op = OP_TAIL_FOLD;
            ST_FIN_C2:    cmd.op = OP_FIN_C2;
            ST_OUT:       cmd.op = status.out_free ? OP_OUT : OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    a_word_starts_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ABSORB && s_tuser && status.word_full) |=> state_reg == ST_BLK_C1)
        else $error("completed word did not start block mix");

    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !status.out_free) |=> state_reg == ST_OUT)
        else $error("result dropped while output register busy");

    a_tail_fold_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL_FOLD) |-> $past(state_reg) == ST_TAIL_C2)
        else $error("tail fold without tail multiply");

endmodule

`default_nettype wire

[hw/rtl/msr_datapath.sv]
// Datapath for the shard router: config registers, key state, one shared
// 32x32 multiplier and the output register. Depends on msr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msr_datapath
    import msr_pkg::*;
#(
    parameter int MAX_SHARD_BITS = MAX_SHARD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  has_byte,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [HASH_W-1:0]          hash,
    output logic [SHARD_W-1:0]         shard
);

    localparam logic [5:0] MAX_BITS = 6'(MAX_SHARD_BITS);

    logic [31:0]             seed_reg;
    logic [SHARD_BITS_W-1:0] shard_bits_reg;

    logic        in_key_reg, in_key_next;
    logic [31:0] h_reg, h_next;
    logic [23:0] pw_reg, pw_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] work_reg, work_next;

    logic               m_valid_reg, m_valid_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [SHARD_W-1:0] shard_reg, shard_next;

    logic [31:0] base_h, base_len;
    logic [23:0] base_pw;
    logic [1:0]  base_biw;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] fin_x, fold_x, w15, w13, fin_hash;
    logic [5:0]  bits_eff;
    logic [SHARD_W-1:0] mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= '0;
            shard_bits_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SEED:       seed_reg       <= cfg_data;
                REG_SHARD_BITS: shard_bits_reg <= cfg_data[SHARD_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // a fresh key starts from the seed
    assign base_h   = in_key_reg ? h_reg   : seed_reg;
    assign base_pw  = in_key_reg ? pw_reg  : 24'd0;
    assign base_biw = in_key_reg ? biw_reg : 2'd0;
    assign base_len = in_key_reg ? len_reg : 32'd0;

    assign w15    = {work_reg[16:0], work_reg[31:17]};
    assign fold_x = h_reg ^ work_reg;
    assign w13    = {fold_x[18:0], fold_x[31:19]};
    assign fin_x  = (h_reg ^ len_reg) ^ {16'd0, h_reg[31:16] ^ len_reg[31:16]};

    // shared multiplier, low 32 bits of the product
    always_comb begin
        mul_a = work_reg;
        mul_b = MIX_C1;
        case (cmd.op)
            OP_BLK_C1:  begin mul_a = work_reg;                      mul_b = MIX_C1; end
            OP_BLK_C2:  begin mul_a = w15;                           mul_b = MIX_C2; end
            OP_TAIL_C1: begin mul_a = {8'd0, pw_reg};                mul_b = MIX_C1; end
            OP_FIN_C1:  begin mul_a = fin_x;                         mul_b = FIN_C1; end
            OP_FIN_C2:  begin mul_a = work_reg ^ (work_reg >> 13);   mul_b = FIN_C2; end
            default:    begin mul_a = work_reg;                      mul_b = MIX_C1; end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign fin_hash = work_reg ^ (work_reg >> 16);
    assign bits_eff = (6'(shard_bits_reg) > MAX_BITS) ? MAX_BITS : 6'(shard_bits_reg);

    always_comb begin
        for (int i = 0; i < SHARD_W; i++) begin
            mask[i] = (6'(i) < bits_eff);
        end
    end

    always_comb begin
        in_key_next  = in_key_reg;
        h_next       = h_reg;
        pw_next      = pw_reg;
        biw_next     = biw_reg;
        len_next     = len_reg;
        work_next    = work_reg;
        m_valid_next = m_valid_reg && !m_tready;
        hash_next    = hash_reg;
        shard_next   = shard_reg;
        case (cmd.op)
            OP_ABSORB: begin
                in_key_next = 1'b1;
                h_next      = base_h;
                pw_next     = base_pw;
                biw_next    = base_biw;
                len_next    = base_len;
                if (has_byte) begin
                    len_next = base_len + 32'd1;
                    if (base_biw == 2'd3) begin
                        work_next = {data_byte, base_pw};
                        pw_next   = 24'd0;
                        biw_next  = 2'd0;
                    end else begin
                        case (base_biw)
                            2'd0:    pw_next = {base_pw[23:8], data_byte};
                            2'd1:    pw_next = {base_pw[23:16], data_byte, base_pw[7:0]};
                            default: pw_next = {data_byte, base_pw[15:0]};
                        endcase
                        biw_next = base_biw + 2'd1;
                    end
                end
            end
            OP_BLK_C1, OP_BLK_C2, OP_TAIL_C1, OP_FIN_C1, OP_FIN_C2: begin
                work_next = prod;
            end
            OP_BLK_FOLD: begin
                h_next = {w13[29:0], 2'b00} + w13 + MIX_ADD;
            end
            OP_TAIL_FOLD: begin
                h_next   = h_reg ^ work_reg;
                biw_next = 2'd0;
            end
            OP_OUT: begin
                m_valid_next = 1'b1;
                hash_next    = fin_hash;
                shard_next   = fin_hash[SHARD_W-1:0] & mask;
                in_key_next  = 1'b0;
                biw_next     = 2'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg  <= 1'b0;
            biw_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            in_key_reg  <= in_key_next;
            biw_reg     <= biw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg     <= h_next;
        pw_reg    <= pw_next;
        len_reg   <= len_next;
        work_reg  <= work_next;
        hash_reg  <= hash_next;
        shard_reg <= shard_next;
    end

    assign status.word_full    = (base_biw == 2'd3);
    assign status.tail_pending = (biw_reg != 2'd0);
    assign status.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign hash     = hash_reg;
    assign shard    = shard_reg;

    a_absorb_opens_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ABSORB) |=> in_key_reg)
        else $error("key not open after absorbing a request");

    a_out_closes_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |=> (m_valid_reg && !in_key_reg))
        else $error("result not loaded or key not closed");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=>
            (m_valid_reg && $stable(hash_reg) && $stable(shard_reg)))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

[hw/rtl/murmur3_shard_router_top.sv]
// MurmurHash3 x86_32 shard router, top level. Depends on msr_pkg, msr_ctrl,
// msr_datapath.
// Requests are taken only in idle; a byte completing a 4-byte word then runs
// the block mix, a last request the tail mix, finalizer and any wait for the
// output register. All mix steps share the one 32x32 multiplier.
// Reset: synchronous active-low aresetn clears seed, shard_bits and key state.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_shard_router_top
    import msr_pkg::*;
#(
    parameter int MAX_SHARD_BITS = MAX_SHARD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tuser,   // [0] has_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata    // [31:0] hash, [47:32] shard
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [HASH_W-1:0]  hash;
    logic [SHARD_W-1:0] shard;

    msr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    msr_datapath #(
        .MAX_SHARD_BITS (MAX_SHARD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (s_tdata),
        .has_byte  (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .hash      (hash),
        .shard     (shard)
    );

    assign m_tdata = {shard, hash};

endmodule

`default_nettype wire
